// ===== src/mipq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mipq_pkg
// Shared types and codes for the min-id process queue.
// ----------------------------------------------------------------------------
package mipq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int OCC_W     = 5;

	typedef enum logic {
		CMD_INSERT  = 1'b0,
		CMD_EXTRACT = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_FIN
	} state_t;

	// id sits in the low bits, matching the word layout on the ports
	typedef struct packed {
		logic [15:0] svc;
		logic [15:0] arr;
		logic [15:0] id;
	} rec_t;

	typedef struct packed {
		logic [OCC_W-1:0] occupancy;
		rec_t             rec;
		status_t          status;
	} res_t;

endpackage
`default_nettype wire

// ===== src/mipq_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mipq_mem
// Record table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mipq_mem
	import mipq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire rec_t          wdata,
	input  wire logic [AW-1:0] raddr,
	output rec_t               rdata
);

	rec_t mem_q [DEPTH];
	rec_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== src/mipq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mipq_ctrl
// Command sequencer: appends on insert, scans the table with one comparator
// on extract, then closes the gap by moving later entries down one place.
// ----------------------------------------------------------------------------
module mipq_ctrl
	import mipq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire cmd_t          in_cmd,
	input  wire rec_t          in_rec,
	output logic               res_valid,
	input  wire logic          res_ready,
	output res_t               res,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output rec_t               mem_wdata,
	output logic [AW-1:0]      mem_raddr,
	input  wire rec_t          mem_rdata
);

	state_t          state_q, state_d;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   ra_q;
	logic            v_s1;
	logic [AW-1:0]   idx_s1;
	rec_t            best_q;
	logic [AW-1:0]   best_idx_q;
	status_t         stat_q;
	rec_t            rec_q;

	logic            issue;
	logic            full;
	logic            take_new;
	logic [AW-1:0]   best_idx_nxt;
	logic            scan_last;
	logic            shift_done;

	assign full         = (cnt_q >= CW'(DEPTH));
	assign take_new     = (idx_s1 == '0) || (mem_rdata.id < best_q.id);
	assign best_idx_nxt = take_new ? idx_s1 : best_idx_q;
	assign scan_last    = v_s1 && (CW'(idx_s1) == (cnt_q - CW'(1)));
	assign shift_done   = (ra_q >= cnt_q) && !v_s1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_cmd == CMD_EXTRACT && cnt_q != '0) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				if (shift_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and table port
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		res_valid = (state_q == ST_FIN);
		mem_we    = 1'b0;
		mem_waddr = AW'(cnt_q);
		mem_wdata = in_rec;
		mem_raddr = AW'(ra_q);
		issue     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				mem_we = in_valid && (in_cmd == CMD_INSERT) && !full;
			end
			ST_SCAN: begin
				issue = (ra_q < cnt_q);
			end
			ST_SHIFT: begin
				issue     = (ra_q < cnt_q);
				mem_we    = v_s1;
				mem_waddr = idx_s1;
				mem_wdata = mem_rdata;
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	assign res.status    = stat_q;
	assign res.rec       = rec_q;
	assign res.occupancy = OCC_W'(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ra_q    <= '0;
			v_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (in_cmd == CMD_INSERT && !full) begin
							cnt_q <= cnt_q + CW'(1);
						end
						ra_q <= '0;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						ra_q <= ra_q + CW'(1);
					end
					// move phase reads from the entry after the winner
					if (scan_last) begin
						ra_q <= CW'(best_idx_nxt) + CW'(1);
					end
				end
				ST_SHIFT: begin
					if (issue) begin
						ra_q <= ra_q + CW'(1);
					end
					if (shift_done) begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				default: begin
					ra_q <= ra_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					rec_q <= '0;
					if (in_cmd == CMD_INSERT) begin
						stat_q <= full ? STAT_FULL : STAT_OK;
					end else begin
						stat_q <= STAT_EMPTY;
					end
				end
			end
			ST_SCAN: begin
				idx_s1 <= AW'(ra_q);
				// strict less-than keeps the earliest of equal ids
				if (v_s1 && take_new) begin
					best_q     <= mem_rdata;
					best_idx_q <= idx_s1;
				end
			end
			ST_SHIFT: begin
				idx_s1 <= AW'(ra_q - CW'(1));
				if (shift_done) begin
					stat_q <= STAT_OK;
					rec_q  <= best_q;
				end
			end
			default: begin
				idx_s1 <= idx_s1;
			end
		endcase
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_shift_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT && mem_we) |-> (CW'(mem_waddr) < (cnt_q - CW'(1))))
		else $error("move writes past the last entry");

	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && stat_q == STAT_EMPTY) |-> (cnt_q == '0))
		else $error("empty status with entries held");

	a_extract_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT && shift_done) |=> (cnt_q == $past(cnt_q) - CW'(1)))
		else $error("extract did not remove an entry");

	a_no_scan_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_FIN) |-> !mem_we)
		else $error("table written outside insert or move");

endmodule
`default_nettype wire

// ===== src/min_id_process_queue_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// min_id_process_queue_core
// Bounded table of process records with insert and smallest-id extract.
// Input words arrive on s_axis: tuser is the command, tdata the record. Every
// command gives one result word on m_axis: tuser is the status (ok, full,
// empty), tdata the extracted record (zero for anything but a successful
// extract) and the entry count afterwards. Equal ids go out in insertion order.
// One command at a time; s_axis_tready is low while a command is in progress.
// An insert or a failed command skips the scan and move phases and goes
// straight to the result state. An extract first walks the table with the
// single comparator through the registered read port, then moves the later
// entries down a place through the single write port, then gives the result.
// The sequencer returns to idle before the next accept, so it takes no new
// command until the result of the last one has left the result state.
// Reset clears the entry count; table contents need no clearing.
// If m_axis_tready is low the result waits in the output register; the next
// command is still accepted, its result held back until the register empties.
// ----------------------------------------------------------------------------
module min_id_process_queue_core
	import mipq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,   // proc_id, arrival_time, service_time
	input  wire logic        s_axis_tuser,   // command
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [55:0]      m_axis_tdata,   // out_id, out_arrival, out_service,
	                                         // occupancy, zero pad
	output logic [1:0]       m_axis_tuser    // status
);

	rec_t          in_rec;
	cmd_t          in_cmd;
	res_t          res;
	logic          res_valid;
	logic          res_ready;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	rec_t          mem_wdata;
	logic [AW-1:0] mem_raddr;
	rec_t          mem_rdata;
	logic          out_valid_q;
	res_t          out_q;

	assign in_rec.id  = s_axis_tdata[15:0];
	assign in_rec.arr = s_axis_tdata[31:16];
	assign in_rec.svc = s_axis_tdata[47:32];
	assign in_cmd     = cmd_t'(s_axis_tuser);

	mipq_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (in_cmd),
		.in_rec    (in_rec),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	mipq_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register frees the sequencer while the receiver stalls
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {3'b000, out_q.occupancy, out_q.rec.svc, out_q.rec.arr,
		out_q.rec.id};

endmodule
`default_nettype wire

// ===== bench/min_id_queue_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_id_queue_checker
// Watches both stream channels of the min-id process queue, keeps its own
// copy of the record table, predicts one reply word per command word and
// compares every reply word field by field, oldest first.
// ----------------------------------------------------------------------------
module min_id_queue_checker
	import mipq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,   // proc_id, arrival_time, service_time
	input  wire logic        s_axis_tuser,   // command
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [55:0] m_axis_tdata,   // out_id, out_arrival, out_service,
	                                         // occupancy, zero pad
	input  wire logic [1:0]  m_axis_tuser,   // status
	output int               fail_count,
	output int               outstanding,
	output int               extracted_count,
	output int               full_count,
	output int               empty_count
);

	localparam int MAX_REPORTS = 40;

	typedef struct {
		status_t          status;
		rec_t             rec;
		logic [OCC_W-1:0] occupancy;
	} reply_t;

	rec_t   held [DEPTH];
	int     held_count;
	int     mismatches;
	int     n_extracted;
	int     n_full;
	int     n_empty;
	reply_t awaited_replies [$];

	// table model: append on insert, strict less-than scan and close the gap on extract
	function automatic reply_t run_table_command(cmd_t cmd, rec_t rec_in);
		reply_t r;
		int     best;
		r.rec = '0;
		if (cmd == CMD_INSERT) begin
			if (held_count >= DEPTH) begin
				r.status = STAT_FULL;
				n_full++;
			end else begin
				held[held_count] = rec_in;
				held_count++;
				r.status = STAT_OK;
			end
		end else if (held_count == 0) begin
			r.status = STAT_EMPTY;
			n_empty++;
		end else begin
			best = 0;
			for (int i = 1; i < held_count; i++)
				if (held[i].id < held[best].id)
					best = i;
			r.rec = held[best];
			for (int i = best; i + 1 < held_count; i++)
				held[i] = held[i + 1];
			held_count--;
			r.status = STAT_OK;
			n_extracted++;
		end
		r.occupancy = OCC_W'(held_count);
		return r;
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			held_count = 0;
			awaited_replies.delete();
		end else begin
			// replies first: a reply at this edge always belongs to an earlier command
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: reply word with none awaited, expected nothing, got %h / %h",
							$time, m_axis_tuser, m_axis_tdata);
				end else begin
					want = awaited_replies.pop_front();
					check_field("status", 16'(want.status), 16'(m_axis_tuser));
					check_field("out_id", want.rec.id, m_axis_tdata[15:0]);
					check_field("out_arrival", want.rec.arr, m_axis_tdata[31:16]);
					check_field("out_service", want.rec.svc, m_axis_tdata[47:32]);
					check_field("occupancy", 16'(want.occupancy), 16'(m_axis_tdata[52:48]));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				awaited_replies.push_back(run_table_command(cmd_t'(s_axis_tuser),
					rec_t'(s_axis_tdata)));
		end
		fail_count      <= mismatches;
		outstanding     <= awaited_replies.size();
		extracted_count <= n_extracted;
		full_count      <= n_full;
		empty_count     <= n_empty;
	end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives insert and extract command words into the min-id process queue,
// stalls the reply side at random and leaves prediction and comparison to
// the checker; prints the verdict once every reply word has come back.
// ----------------------------------------------------------------------------
module testbench;
	import mipq_pkg::*;

	localparam int DEPTH        = DEPTH_DEF;
	localparam int RANDOM_WORDS = 880;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SETTLE       = 100;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata  = '0;
	logic        s_axis_tuser  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	int fail_count;
	int outstanding;
	int extracted_count;
	int full_count;
	int empty_count;
	int cycle_count = 0;
	int words_sent  = 0;
	int ready_hold  = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	min_id_process_queue_core #(.DEPTH(DEPTH)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	min_id_queue_checker #(.DEPTH(DEPTH)) checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.extracted_count (extracted_count),
		.full_count      (full_count),
		.empty_count     (empty_count)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: timeout with %0d reply words outstanding", $time, outstanding);
		$display("TEST FAILED");
		$finish;
	end

	// reply side: mostly short ready stretches and short stalls, some long ones of each
	always @(posedge clk) begin
		int pick;
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				m_axis_tready <= 1'b1;
				ready_hold    <= $urandom_range(1, 20);
			end else if (pick < 55) begin
				m_axis_tready <= 1'b1;
				ready_hold    <= $urandom_range(50, 150);
			end else if (pick < 88) begin
				m_axis_tready <= 1'b0;
				ready_hold    <= $urandom_range(0, 3);
			end else begin
				m_axis_tready <= 1'b0;
				ready_hold    <= $urandom_range(10, 40);
			end
		end
	end

	function automatic int next_gap(bit quiet);
		int pick;
		if (quiet)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// 0: tiny id pool for many equal ids, 1: full range, 2: corner ids
	function automatic logic [15:0] make_id(int mode);
		case (mode)
			0: return 16'($urandom_range(0, 7));
			2: begin
				case ($urandom_range(0, 3))
					0: return 16'h0000;
					1: return 16'h0001;
					2: return 16'hFFFE;
					default: return 16'hFFFF;
				endcase
			end
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] make_time();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic pause(input int cycles);
		if (cycles > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic send_word(input cmd_t cmd, input logic [15:0] id, input logic [15:0] arr,
		input logic [15:0] svc);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {svc, arr, id};
		do @(posedge clk); while (!s_axis_tready);
		words_sent++;
	endtask

	initial begin
		logic [15:0] fill_ids [16];
		logic [15:0] arr;
		logic [15:0] svc;
		int          rand_sent;
		int          phase_kind;
		int          phase_len;
		int          insert_pct;
		int          id_mode;
		bit          quiet;
		cmd_t        cmd;

		// duplicates of the smallest id and of 5 check that equal ids leave oldest first
		fill_ids = '{16'hFFFF, 16'h0000, 16'h0005, 16'h0005, 16'h8000, 16'h0000, 16'h7FFF,
			16'h0005, 16'h0001, 16'hFFFE, 16'h1234, 16'h0000, 16'hFFFF, 16'h0002,
			16'hABCD, 16'h0003};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extract from an empty table
		send_word(CMD_EXTRACT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		// fill to the brim, then one insert too many
		for (int i = 0; i < DEPTH; i++) begin
			arr = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'($urandom);
			svc = (i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : 16'($urandom);
			pause(next_gap(i < 8));
			send_word(CMD_INSERT, fill_ids[i % 16], arr, svc);
		end
		send_word(CMD_INSERT, 16'h4242, 16'hFFFF, 16'hFFFF);
		for (int i = 0; i < 5; i++) begin
			pause(next_gap(1'b0));
			send_word(CMD_EXTRACT, 16'($urandom), 16'($urandom), 16'($urandom));
		end

		// random phases that lean toward filling, draining or neither
		rand_sent = 0;
		while (rand_sent < RANDOM_WORDS) begin
			phase_kind = $urandom_range(0, 2);
			phase_len  = $urandom_range(8, 48);
			quiet      = ($urandom_range(0, 3) == 0);
			id_mode    = $urandom_range(0, 2);
			insert_pct = (phase_kind == 0) ? 80 : (phase_kind == 1) ? 20 : 50;
			for (int k = 0; k < phase_len && rand_sent < RANDOM_WORDS; k++) begin
				cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_EXTRACT;
				pause(next_gap(quiet));
				send_word(cmd, make_id(id_mode), make_time(), make_time());
				rand_sent++;
			end
		end
		s_axis_tvalid <= 1'b0;

		// let the count of the last accepted word settle before waiting on it
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Sent %0d command words: %0d extracts returned a record,", words_sent,
			extracted_count);
		$display("%0d inserts met a full table, %0d extracts met an empty one.", full_count,
			empty_count);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
